// ===== hw/rtl/atrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package atrt_pkg;

    // Fixed field widths
    localparam int TEMP_W  = 32;
    localparam int DEV_W   = 24;
    localparam int FRAC_W  = 16;
    localparam int CNT_W   = 16;
    localparam int TICK_W  = 32;
    localparam int STAGE_W = 8;
    localparam int SUM_W   = 64;
    localparam int STAT_W  = 2;
    localparam int CIDX_W  = 3;

    typedef logic [TEMP_W-1:0]  temp_t;
    typedef logic [DEV_W-1:0]   dev_t;
    typedef logic [FRAC_W-1:0]  frac_t;
    typedef logic [CNT_W-1:0]   count_t;
    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [STAGE_W-1:0] stage_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [STAT_W-1:0]  status_t;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Result status codes
    localparam status_t STATUS_RUNNING   = 2'd0;
    localparam status_t STATUS_CONVERGED = 2'd1;
    localparam status_t STATUS_FAILED    = 2'd2;

    // Register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_TARGET_DEV = 3'd0,
        CFG_TEMP_FLOOR = 3'd1,
        CFG_TEMP_CEIL  = 3'd2,
        CFG_INIT_STEP  = 3'd3,
        CFG_STEP_FACT  = 3'd4,
        CFG_TOLERANCE  = 3'd5,
        CFG_PASSES     = 3'd6,
        CFG_MAX_STEPS  = 3'd7
    } cfg_idx_t;

    // Register reset values
    localparam dev_t   RST_TARGET_DEV = 24'd32768;
    localparam temp_t  RST_TEMP_FLOOR = 32'd167772;
    localparam temp_t  RST_TEMP_CEIL  = 32'hFFFF_FFFF;
    localparam temp_t  RST_INIT_STEP  = 32'd336;
    localparam frac_t  RST_STEP_FACT  = 16'd20724;
    localparam frac_t  RST_TOLERANCE  = 16'd655;
    localparam count_t RST_PASSES     = 16'd400;
    localparam tick_t  RST_MAX_STEPS  = 32'd20000000;

    // Run state held between items
    typedef enum logic [1:0] {
        RUN_IDLE   = 2'd0,
        RUN_ACTIVE = 2'd1,
        RUN_CONV   = 2'd2,
        RUN_FAIL   = 2'd3
    } run_state_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_CHECK,
        ST_DIVLOAD,
        ST_DIVIDE,
        ST_TOLMUL,
        ST_COMPARE,
        ST_STEPMUL,
        ST_STEPSET,
        ST_EMIT
    } fsm_state_t;

    // Shared multiplier widths and divider step counter width
    localparam int MUL_A_W  = TEMP_W + 1;
    localparam int MUL_P_W  = MUL_A_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(SUM_W);

endpackage

`default_nettype wire

// ===== hw/rtl/atrt_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface atrt_req_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    atrt_pkg::dev_t      deviation;
    atrt_pkg::temp_t     start_temp;

    modport source (output valid, cmd, deviation, start_temp, input ready);
    modport sink   (input valid, cmd, deviation, start_temp, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/atrt_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface atrt_rsp_if;
    logic                valid;
    logic                ready;
    atrt_pkg::temp_t     temperature;
    atrt_pkg::stage_t    stage_number;
    atrt_pkg::count_t    crossings;
    atrt_pkg::status_t   run_status;

    modport source (output valid, temperature, stage_number, crossings, run_status,
                    input ready);
    modport sink   (input valid, temperature, stage_number, crossings, run_status,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/atrt_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface atrt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [atrt_pkg::CIDX_W-1:0]   index;
    logic [atrt_pkg::TEMP_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/adaptive_temperature_rmsd_tracker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Adaptive temperature tracker.
// req: one beat per command. cmd start loads start_temp and notes the side of
//   the target deviation lies on; in an active run cmd tick moves temperature
//   one step against the deviation, clamps it, counts crossings, sums the stage.
// rsp: exactly one beat per req beat, in order: temperature, stage, crossings
//   and status (running, converged or failed).
// cfg: register writes, always ready; write only while the block is idle.
// Sequence: req is taken only when the sequencer is idle, so no new beat is
//   taken before the last one reaches emit. Every beat passes update and emit;
//   a tick in an active run also passes check. A tick that ends a stage with
//   enough crossings runs a 64-step restoring divider (one quotient bit a
//   cycle) for the stage average, then the shared 33x16 multiplier for the
//   tolerance product and, unless the run converges, for the step product.
// The result sits in an output register, so the next req beat is taken while
//   an earlier result waits; a stalled receiver holds the sequencer in its
//   last state only once a second result is ready.
// Reset: registers return to their defaults, the run is idle, no rsp pending.

module adaptive_temperature_rmsd_tracker_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    atrt_req_if.sink            req,
    atrt_rsp_if.source          rsp,
    atrt_cfg_if.sink            cfg
);

    // Configuration registers
    atrt_pkg::dev_t    tgt_reg;
    atrt_pkg::temp_t   floor_reg;
    atrt_pkg::temp_t   ceil_reg;
    atrt_pkg::temp_t   init_step_reg;
    atrt_pkg::frac_t   factor_reg;
    atrt_pkg::frac_t   tol_reg;
    atrt_pkg::count_t  passes_reg;
    atrt_pkg::tick_t   max_steps_reg;

    // Run state
    atrt_pkg::temp_t      temp_reg,  temp_next;
    atrt_pkg::temp_t      step_reg,  step_next;
    logic                 above_reg, above_next;
    atrt_pkg::count_t     pass_reg,  pass_next;
    atrt_pkg::tick_t      tick_reg,  tick_next;
    atrt_pkg::stage_t     stage_reg, stage_next;
    atrt_pkg::sum_t       sum_reg,   sum_next;
    atrt_pkg::temp_t      prev_reg,  prev_next;
    atrt_pkg::run_state_t run_reg,   run_next;

    // Latched beat and working registers
    logic                 cmd_reg;
    atrt_pkg::dev_t       dev_reg;
    atrt_pkg::temp_t      start_reg;
    atrt_pkg::temp_t      rem_reg,  rem_next;
    atrt_pkg::sum_t       quo_reg,  quo_next;
    logic [atrt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [atrt_pkg::MUL_P_W-1:0]   prod_reg, prod_next;

    // Sequencer
    atrt_pkg::fsm_state_t fsm_reg, fsm_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    atrt_pkg::temp_t      out_temp_reg;
    atrt_pkg::stage_t     out_stage_reg;
    atrt_pkg::count_t     out_cross_reg;
    atrt_pkg::status_t    out_status_reg;

    // Control decoded from state
    logic                 accept;
    logic                 emit_fire;
    logic                 stage_end;
    logic                 div_last;

    // Datapath intermediates
    logic                          above_now;
    logic [atrt_pkg::TEMP_W+1:0]   t_raw;
    logic [atrt_pkg::TEMP_W+1:0]   floor_ext;
    logic [atrt_pkg::TEMP_W+1:0]   ceil_ext;
    logic [atrt_pkg::SUM_W:0]      sum_add;
    logic [atrt_pkg::TEMP_W:0]     trial;
    logic [atrt_pkg::TEMP_W:0]     trial_sub;
    logic                          trial_ge;
    atrt_pkg::temp_t               avg;
    atrt_pkg::temp_t               diff;
    logic [atrt_pkg::MUL_P_W-1:0]  lhs;
    logic [atrt_pkg::MUL_A_W-1:0]  mul_a;
    atrt_pkg::frac_t               mul_b;
    logic [atrt_pkg::MUL_P_W-1:0]  mul_p;
    atrt_pkg::status_t             status_now;

    assign accept    = req.valid && req.ready;
    assign stage_end = (pass_reg >= passes_reg) ||
                       ((max_steps_reg != '0) && (tick_reg >= max_steps_reg));
    assign div_last  = (cnt_reg == {atrt_pkg::DIV_CNT_W{1'b1}});
    assign avg       = quo_reg[atrt_pkg::TEMP_W-1:0];

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg       <= atrt_pkg::RST_TARGET_DEV;
            floor_reg     <= atrt_pkg::RST_TEMP_FLOOR;
            ceil_reg      <= atrt_pkg::RST_TEMP_CEIL;
            init_step_reg <= atrt_pkg::RST_INIT_STEP;
            factor_reg    <= atrt_pkg::RST_STEP_FACT;
            tol_reg       <= atrt_pkg::RST_TOLERANCE;
            passes_reg    <= atrt_pkg::RST_PASSES;
            max_steps_reg <= atrt_pkg::RST_MAX_STEPS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                atrt_pkg::CFG_TARGET_DEV: tgt_reg       <= cfg.data[atrt_pkg::DEV_W-1:0];
                atrt_pkg::CFG_TEMP_FLOOR: floor_reg     <= cfg.data;
                atrt_pkg::CFG_TEMP_CEIL:  ceil_reg      <= cfg.data;
                atrt_pkg::CFG_INIT_STEP:  init_step_reg <= cfg.data;
                atrt_pkg::CFG_STEP_FACT:  factor_reg    <= cfg.data[atrt_pkg::FRAC_W-1:0];
                atrt_pkg::CFG_TOLERANCE:  tol_reg       <= cfg.data[atrt_pkg::FRAC_W-1:0];
                atrt_pkg::CFG_PASSES:     passes_reg    <= cfg.data[atrt_pkg::CNT_W-1:0];
                atrt_pkg::CFG_MAX_STEPS:  max_steps_reg <= cfg.data;
                default:                  tgt_reg       <= tgt_reg;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            atrt_pkg::ST_IDLE:
                if (accept)
                    fsm_next = atrt_pkg::ST_UPDATE;
            atrt_pkg::ST_UPDATE:
                if (cmd_reg == atrt_pkg::CMD_TICK && run_reg == atrt_pkg::RUN_ACTIVE)
                    fsm_next = atrt_pkg::ST_CHECK;
                else
                    fsm_next = atrt_pkg::ST_EMIT;
            atrt_pkg::ST_CHECK:
                if (stage_end && pass_reg >= passes_reg)
                    fsm_next = atrt_pkg::ST_DIVLOAD;
                else
                    fsm_next = atrt_pkg::ST_EMIT;
            atrt_pkg::ST_DIVLOAD:
                fsm_next = atrt_pkg::ST_DIVIDE;
            atrt_pkg::ST_DIVIDE:
                if (div_last)
                    fsm_next = atrt_pkg::ST_TOLMUL;
            atrt_pkg::ST_TOLMUL:
                if (stage_reg == '0)
                    fsm_next = atrt_pkg::ST_STEPMUL;
                else
                    fsm_next = atrt_pkg::ST_COMPARE;
            atrt_pkg::ST_COMPARE:
                if (lhs < prod_reg)
                    fsm_next = atrt_pkg::ST_EMIT;
                else
                    fsm_next = atrt_pkg::ST_STEPMUL;
            atrt_pkg::ST_STEPMUL:
                fsm_next = atrt_pkg::ST_STEPSET;
            atrt_pkg::ST_STEPSET:
                fsm_next = atrt_pkg::ST_EMIT;
            atrt_pkg::ST_EMIT:
                if (emit_fire)
                    fsm_next = atrt_pkg::ST_IDLE;
            default:
                fsm_next = atrt_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req.ready      = (fsm_reg == atrt_pkg::ST_IDLE);
        emit_fire      = (fsm_reg == atrt_pkg::ST_EMIT) && (!out_valid_reg || rsp.ready);
        out_valid_next = out_valid_reg;
        if (emit_fire)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // Shared multiplier: tolerance * (avg + prev), then step * factor
    always_comb
    begin
        if (fsm_reg == atrt_pkg::ST_TOLMUL)
        begin
            mul_a = {1'b0, avg} + {1'b0, prev_reg};
            mul_b = tol_reg;
        end
        else
        begin
            mul_a = {1'b0, step_reg};
            mul_b = factor_reg;
        end
        mul_p = {{atrt_pkg::FRAC_W{1'b0}}, mul_a} * {{atrt_pkg::MUL_A_W{1'b0}}, mul_b};
    end

    // Tick arithmetic, divider step and tolerance compare
    always_comb
    begin
        above_now = dev_reg > tgt_reg;
        floor_ext = {2'b00, floor_reg};
        ceil_ext  = {2'b00, ceil_reg};
        if (above_now)
            t_raw = {2'b00, temp_reg} - {2'b00, step_reg};
        else
            t_raw = {2'b00, temp_reg} + {2'b00, step_reg};

        sum_add = {1'b0, sum_reg} + {{(atrt_pkg::SUM_W - atrt_pkg::TEMP_W + 1){1'b0}}, temp_reg};

        trial     = {rem_reg, quo_reg[atrt_pkg::SUM_W-1]};
        trial_sub = trial - {1'b0, tick_reg};
        trial_ge  = !trial_sub[atrt_pkg::TEMP_W];

        if (avg >= prev_reg)
            diff = avg - prev_reg;
        else
            diff = prev_reg - avg;
        lhs = {diff, 17'd0};
    end

    // Run state updates
    always_comb
    begin
        temp_next  = temp_reg;
        step_next  = step_reg;
        above_next = above_reg;
        pass_next  = pass_reg;
        tick_next  = tick_reg;
        stage_next = stage_reg;
        sum_next   = sum_reg;
        prev_next  = prev_reg;
        run_next   = run_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        case (fsm_reg)
            atrt_pkg::ST_UPDATE:
                if (cmd_reg == atrt_pkg::CMD_START)
                begin
                    temp_next  = start_reg;
                    step_next  = init_step_reg;
                    above_next = above_now;
                    pass_next  = '0;
                    tick_next  = '0;
                    stage_next = '0;
                    sum_next   = '0;
                    prev_next  = '0;
                    run_next   = atrt_pkg::RUN_ACTIVE;
                end
                else if (run_reg == atrt_pkg::RUN_ACTIVE)
                begin
                    // crossing count, then clamp floor first and ceiling second
                    if (above_now != above_reg && pass_reg != '1)
                        pass_next = pass_reg + 1'b1;
                    above_next = above_now;
                    if ($signed(t_raw) < $signed(floor_ext))
                        temp_next = floor_reg;
                    else if ($signed(t_raw) > $signed(ceil_ext))
                        temp_next = ceil_reg;
                    else
                        temp_next = t_raw[atrt_pkg::TEMP_W-1:0];
                    if (tick_reg != '1)
                        tick_next = tick_reg + 1'b1;
                end
            atrt_pkg::ST_CHECK:
            begin
                if (sum_add[atrt_pkg::SUM_W])
                    sum_next = '1;
                else
                    sum_next = sum_add[atrt_pkg::SUM_W-1:0];
                if (stage_end && pass_reg < passes_reg)
                    run_next = atrt_pkg::RUN_FAIL;
            end
            atrt_pkg::ST_DIVLOAD:
            begin
                rem_next = '0;
                quo_next = sum_reg;
                cnt_next = '0;
            end
            atrt_pkg::ST_DIVIDE:
            begin
                // restoring division, one quotient bit per cycle
                rem_next = trial_ge ? trial_sub[atrt_pkg::TEMP_W-1:0]
                                    : trial[atrt_pkg::TEMP_W-1:0];
                quo_next = {quo_reg[atrt_pkg::SUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            atrt_pkg::ST_TOLMUL:
                prod_next = mul_p;
            atrt_pkg::ST_COMPARE:
                if (lhs < prod_reg)
                    run_next = atrt_pkg::RUN_CONV;
            atrt_pkg::ST_STEPMUL:
                prod_next = mul_p;
            atrt_pkg::ST_STEPSET:
            begin
                step_next = prod_reg[atrt_pkg::TEMP_W+15:16];
                prev_next = avg;
                if (stage_reg != '1)
                    stage_next = stage_reg + 1'b1;
                pass_next = '0;
                tick_next = '0;
                sum_next  = '0;
            end
            default:
                temp_next = temp_reg;
        endcase
    end

    // Status code for the result
    always_comb
    begin
        case (run_reg)
            atrt_pkg::RUN_CONV: status_now = atrt_pkg::STATUS_CONVERGED;
            atrt_pkg::RUN_FAIL: status_now = atrt_pkg::STATUS_FAILED;
            default:            status_now = atrt_pkg::STATUS_RUNNING;
        endcase
    end

    // Control and run state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= atrt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            temp_reg      <= '0;
            step_reg      <= '0;
            above_reg     <= 1'b0;
            pass_reg      <= '0;
            tick_reg      <= '0;
            stage_reg     <= '0;
            sum_reg       <= '0;
            prev_reg      <= '0;
            run_reg       <= atrt_pkg::RUN_IDLE;
            cnt_reg       <= '0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            out_valid_reg <= out_valid_next;
            temp_reg      <= temp_next;
            step_reg      <= step_next;
            above_reg     <= above_next;
            pass_reg      <= pass_next;
            tick_reg      <= tick_next;
            stage_reg     <= stage_next;
            sum_reg       <= sum_next;
            prev_reg      <= prev_next;
            run_reg       <= run_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            dev_reg   <= req.deviation;
            start_reg <= req.start_temp;
        end
        if (emit_fire)
        begin
            out_temp_reg   <= temp_reg;
            out_stage_reg  <= stage_reg;
            out_cross_reg  <= pass_reg;
            out_status_reg <= status_now;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.temperature  = out_temp_reg;
    assign rsp.stage_number = out_stage_reg;
    assign rsp.crossings    = out_cross_reg;
    assign rsp.run_status   = out_status_reg;

`ifndef NO_ASSERTIONS
    // an accepted beat starts the sequencer at once
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> fsm_reg == atrt_pkg::ST_UPDATE)
        else $error("sequencer did not start after accepted beat");

    // divider partial remainder stays below the tick count
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == atrt_pkg::ST_DIVIDE |-> rem_reg < tick_reg)
        else $error("divider remainder out of range");

    // stage averaging only happens within an active run
    a_div_active: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == atrt_pkg::ST_DIVIDE |-> run_reg == atrt_pkg::RUN_ACTIVE)
        else $error("division outside an active run");

    // a new stage advances the index by one or holds it saturated
    a_stage_step: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == atrt_pkg::ST_STEPSET |=>
            (stage_reg == $past(stage_reg) + 8'd1) || (stage_reg == 8'hFF))
        else $error("stage index skipped");

    // a pending result is never overwritten while the receiver stalls
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fsm_reg == atrt_pkg::ST_EMIT && out_valid_reg && !rsp.ready |=>
            fsm_reg == atrt_pkg::ST_EMIT)
        else $error("result overwritten under stall");
`endif

endmodule

`default_nettype wire

// ===== bench/adaptive_temperature_rmsd_tracker_unit_test.sv =====
`timescale 1ns / 1ps

module adaptive_temperature_rmsd_tracker_unit_test;

    import atrt_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned ITEM_TARGET  = 1000;
    localparam int unsigned REPORT_MAX   = 10;

    typedef struct packed {
        logic  cmd;
        dev_t  deviation;
        temp_t start_temp;
    } tracker_cmd_t;

    typedef struct packed {
        temp_t   temperature;
        stage_t  stage_number;
        count_t  crossings;
        status_t run_status;
    } tracker_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    atrt_req_if req_bus();
    atrt_rsp_if rsp_bus();
    atrt_cfg_if reg_bus();

    adaptive_temperature_rmsd_tracker_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus),
        .cfg   (reg_bus)
    );

    // Register shadow, follows every accepted write beat
    dev_t   reg_target    = RST_TARGET_DEV;
    temp_t  reg_floor     = RST_TEMP_FLOOR;
    temp_t  reg_ceiling   = RST_TEMP_CEIL;
    temp_t  reg_init_step = RST_INIT_STEP;
    frac_t  reg_factor    = RST_STEP_FACT;
    frac_t  reg_tol       = RST_TOLERANCE;
    count_t reg_passes    = RST_PASSES;
    tick_t  reg_max_steps = RST_MAX_STEPS;

    // Tracker state as predicted
    temp_t      trk_temp      = '0;
    temp_t      trk_step      = '0;
    logic       trk_above     = 1'b0;
    count_t     trk_crossings = '0;
    tick_t      trk_ticks     = '0;
    stage_t     trk_stage     = '0;
    sum_t       trk_sum       = '0;
    temp_t      trk_prev_avg  = '0;
    run_state_t trk_state     = RUN_IDLE;

    tracker_cmd_t    pending_cmds[$];
    tracker_result_t expected_results[$];

    int unsigned failures       = 0;
    int unsigned items_accepted = 0;
    int unsigned items_queued   = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned send_gap       = 0;
    int unsigned send_calm      = 0;
    int unsigned stall_left     = 0;
    int unsigned rsp_calm       = 0;
    logic        req_taken      = 1'b0;
    logic        hold_rsp       = 1'b0;

    function automatic void load_register(cfg_idx_t idx, temp_t value);
        case (idx)
            CFG_TARGET_DEV: reg_target    = value[DEV_W-1:0];
            CFG_TEMP_FLOOR: reg_floor     = value;
            CFG_TEMP_CEIL:  reg_ceiling   = value;
            CFG_INIT_STEP:  reg_init_step = value;
            CFG_STEP_FACT:  reg_factor    = value[FRAC_W-1:0];
            CFG_TOLERANCE:  reg_tol       = value[FRAC_W-1:0];
            CFG_PASSES:     reg_passes    = value[CNT_W-1:0];
            CFG_MAX_STEPS:  reg_max_steps = value;
        endcase
    endfunction

    // End of stage: fail, converge, or shrink the step and open the next stage
    function automatic void close_stage();
        sum_t  quotient;
        sum_t  gap_abs;
        sum_t  lhs;
        sum_t  rhs;
        sum_t  scaled;
        temp_t avg;
        if (trk_crossings < reg_passes)
        begin
            trk_state = RUN_FAIL;
            return;
        end
        quotient = trk_sum / sum_t'(trk_ticks);
        avg      = quotient[TEMP_W-1:0];
        if (trk_stage != '0)
        begin
            gap_abs = (avg >= trk_prev_avg) ? sum_t'(avg - trk_prev_avg)
                                            : sum_t'(trk_prev_avg - avg);
            lhs = gap_abs << 17;
            rhs = sum_t'(reg_tol) * (sum_t'(avg) + sum_t'(trk_prev_avg));
            if (lhs < rhs)
            begin
                trk_state = RUN_CONV;
                return;
            end
        end
        trk_prev_avg = avg;
        scaled       = (sum_t'(trk_step) * sum_t'(reg_factor)) >> FRAC_W;
        trk_step     = scaled[TEMP_W-1:0];
        if (trk_stage != '1)
            trk_stage++;
        trk_crossings = '0;
        trk_ticks     = '0;
        trk_sum       = '0;
    endfunction

    // One tick: steer against the deviation, clamp, count, sum
    function automatic void step_tracker(dev_t dev);
        logic   above;
        longint moved;
        above = dev > reg_target;
        if (above != trk_above)
        begin
            if (trk_crossings != '1)
                trk_crossings++;
            trk_above = above;
        end
        moved = above ? longint'(trk_temp) - longint'(trk_step)
                      : longint'(trk_temp) + longint'(trk_step);
        // floor wins over ceiling when the two are crossed
        if (moved < longint'(reg_floor))
            moved = longint'(reg_floor);
        else if (moved > longint'(reg_ceiling))
            moved = longint'(reg_ceiling);
        trk_temp = moved[TEMP_W-1:0];
        if (trk_sum > ~sum_t'(0) - sum_t'(trk_temp))
            trk_sum = '1;
        else
            trk_sum = trk_sum + sum_t'(trk_temp);
        if (trk_ticks != '1)
            trk_ticks++;
        if (trk_crossings >= reg_passes ||
            (reg_max_steps != '0 && trk_ticks >= reg_max_steps))
            close_stage();
    endfunction

    function automatic tracker_result_t apply_command(tracker_cmd_t c);
        tracker_result_t res;
        if (c.cmd == CMD_START)
        begin
            trk_temp      = c.start_temp;
            trk_step      = reg_init_step;
            trk_above     = c.deviation > reg_target;
            trk_crossings = '0;
            trk_ticks     = '0;
            trk_stage     = '0;
            trk_sum       = '0;
            trk_prev_avg  = '0;
            trk_state     = RUN_ACTIVE;
        end
        else if (trk_state == RUN_ACTIVE)
            step_tracker(c.deviation);
        res.temperature  = trk_temp;
        res.stage_number = trk_stage;
        res.crossings    = trk_crossings;
        case (trk_state)
            RUN_CONV: res.run_status = STATUS_CONVERGED;
            RUN_FAIL: res.run_status = STATUS_FAILED;
            default:  res.run_status = STATUS_RUNNING;
        endcase
        return res;
    endfunction

    function automatic void check_result(tracker_result_t got);
        tracker_result_t want;
        if (expected_results.size() == 0)
        begin
            failures++;
            if (failures <= REPORT_MAX)
                $display("unexpected result beat: temp %h stage %0d crossings %0d status %0d",
                         got.temperature, got.stage_number, got.crossings, got.run_status);
            return;
        end
        want = expected_results.pop_front();
        if (got.temperature !== want.temperature || got.stage_number !== want.stage_number ||
            got.crossings !== want.crossings || got.run_status !== want.run_status)
        begin
            failures++;
            if (failures <= REPORT_MAX)
                $display("result mismatch: exp temp %h stage %0d crossings %0d status %0d, %s",
                         want.temperature, want.stage_number, want.crossings, want.run_status,
                         $sformatf("got temp %h stage %0d crossings %0d status %0d",
                                   got.temperature, got.stage_number, got.crossings,
                                   got.run_status));
        end
    endfunction

    // Gap length: mostly none or short, a few long, with calm stretches
    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(80, 20);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(150, 40);
    endfunction

    // Deviation on the asked side, or on target if none lies above; on target is below
    function automatic dev_t pick_dev(logic high_side, dev_t aim);
        if (high_side && aim != {DEV_W{1'b1}})
            return dev_t'($urandom_range({DEV_W{1'b1}}, aim + 1));
        if (high_side || $urandom_range(0, 7) == 0)
            return aim;
        return dev_t'($urandom_range(aim, 0));
    endfunction

    function automatic void queue_cmd(logic cmd, dev_t dev, temp_t t0);
        pending_cmds.push_back(tracker_cmd_t'{cmd, dev, t0});
        items_queued++;
    endfunction

    // A start followed by ticks that swing around the target
    function automatic void queue_run(dev_t aim, temp_t lo, temp_t hi);
        logic        side;
        int unsigned flip;
        temp_t       t0;
        side = 1'($urandom_range(1, 0));
        flip = $urandom_range(80, 15);
        if (lo > hi || $urandom_range(0, 3) == 0)
            t0 = $urandom;
        else
            t0 = $urandom_range(hi, lo);
        queue_cmd(CMD_START, pick_dev(side, aim), t0);
        repeat ($urandom_range(40, 6))
        begin
            if ($urandom_range(0, 99) < flip)
                side = ~side;
            if ($urandom_range(0, 11) == 0)
                queue_cmd(CMD_TICK, dev_t'($urandom), $urandom);
            else
                queue_cmd(CMD_TICK, pick_dev(side, aim), $urandom);
        end
    endfunction

    task automatic write_reg(cfg_idx_t idx, temp_t value);
        @(negedge clk);
        reg_bus.valid <= 1'b1;
        reg_bus.index <= idx;
        reg_bus.data  <= value;
        do
            @(posedge clk);
        while (!reg_bus.ready);
    endtask

    task automatic apply_settings(dev_t aim, temp_t lo, temp_t hi, temp_t step_v,
                                  frac_t factor_v, frac_t tol_v, count_t passes_v,
                                  tick_t max_v);
        write_reg(CFG_TARGET_DEV, temp_t'(aim));
        write_reg(CFG_TEMP_FLOOR, lo);
        write_reg(CFG_TEMP_CEIL, hi);
        write_reg(CFG_INIT_STEP, step_v);
        write_reg(CFG_STEP_FACT, temp_t'(factor_v));
        write_reg(CFG_TOLERANCE, temp_t'(tol_v));
        write_reg(CFG_PASSES, temp_t'(passes_v));
        write_reg(CFG_MAX_STEPS, max_v);
        @(negedge clk);
        reg_bus.valid <= 1'b0;
    endtask

    // Wait for every command to be answered, then let the block go quiet
    task automatic settle();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || req_bus.valid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Command driver
    always @(negedge clk)
    begin : drive_req
        tracker_cmd_t nxt;
        if (!rst_n)
            req_bus.valid <= 1'b0;
        else if (!req_bus.valid || req_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                req_bus.valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                nxt = pending_cmds.pop_front();
                req_bus.valid      <= 1'b1;
                req_bus.cmd        <= nxt.cmd;
                req_bus.deviation  <= nxt.deviation;
                req_bus.start_temp <= nxt.start_temp;
                send_gap = next_gap(send_calm);
            end
            else
                req_bus.valid <= 1'b0;
        end
    end

    // Result receiver, with random stalls and the long hold-off
    always @(negedge clk)
    begin
        if (!rst_n || hold_rsp)
            rsp_bus.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= 1'b1;
            stall_left = next_gap(rsp_calm);
        end
    end

    // Monitor: register shadow, result check, then prediction for the new beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= req_bus.valid && req_bus.ready;
            if (reg_bus.valid && reg_bus.ready)
                load_register(cfg_idx_t'(reg_bus.index), reg_bus.data);
            if (rsp_bus.valid && rsp_bus.ready)
                check_result(tracker_result_t'{rsp_bus.temperature, rsp_bus.stage_number,
                                               rsp_bus.crossings, rsp_bus.run_status});
            if (req_bus.valid && req_bus.ready)
            begin
                expected_results.push_back(apply_command(tracker_cmd_t'{req_bus.cmd,
                    req_bus.deviation, req_bus.start_temp}));
                items_accepted++;
            end
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                (reg_bus.valid && reg_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Long receiver hold-off while commands keep coming, so the block backs up
    initial
    begin : rsp_hold_off
        do
            @(posedge clk);
        while (items_accepted < 200 || pending_cmds.size() < 20);
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
    end

    initial
    begin : stimulus
        dev_t        aim;
        temp_t       lo;
        temp_t       hi;
        temp_t       step_v;
        frac_t       factor_v;
        frac_t       tol_v;
        count_t      passes_v;
        tick_t       max_v;
        int unsigned r;

        req_bus.valid      = 1'b0;
        req_bus.cmd        = CMD_START;
        req_bus.deviation  = '0;
        req_bus.start_temp = '0;
        rsp_bus.ready      = 1'b0;
        reg_bus.valid      = 1'b0;
        reg_bus.index      = CFG_TARGET_DEV;
        reg_bus.data       = '0;

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Defaults: tick while idle, clamp at floor, on-target deviation, saturate high
        queue_cmd(CMD_TICK, '0, '0);
        queue_cmd(CMD_START, '0, '0);
        queue_cmd(CMD_TICK, '1, '0);
        queue_cmd(CMD_TICK, RST_TARGET_DEV, '1);
        queue_cmd(CMD_TICK, RST_TARGET_DEV + 1, '0);
        queue_cmd(CMD_START, '1, '1);
        queue_cmd(CMD_TICK, '0, '1);
        queue_cmd(CMD_TICK, RST_TARGET_DEV + 1, '0);
        queue_cmd(CMD_START, RST_TARGET_DEV, 32'h8000_0000);

        // Unreachable target, zero ceiling, one-tick limit: unclamped start, then fail
        settle();
        apply_settings('1, '0, '0, '1, '0, '0, 16'd1, 32'd1);
        queue_cmd(CMD_START, '0, 32'h1234_5678);
        queue_cmd(CMD_TICK, '1, '0);
        queue_cmd(CMD_TICK, '0, '1);
        queue_cmd(CMD_START, '1, '1);

        // One crossing per stage with full tolerance: converges in stage one
        settle();
        apply_settings(24'd1000, '0, '1, 32'd256, '1, '1, 16'd1, '0);
        queue_cmd(CMD_START, '0, 32'h0100_0000);
        queue_cmd(CMD_TICK, 24'd2000, '0);
        queue_cmd(CMD_TICK, 24'd1000, '0);
        queue_cmd(CMD_TICK, 24'd5, '0);

        // Floor above ceiling: below floor gives floor, otherwise ceiling
        settle();
        apply_settings(24'h80_0000, 32'h9000_0000, 32'h1000_0000, 32'h10, 16'h8000, '0,
                       16'd2, '1);
        queue_cmd(CMD_START, '0, 32'h5000_0000);
        queue_cmd(CMD_TICK, '1, '0);
        queue_cmd(CMD_TICK, '0, '0);
        queue_cmd(CMD_TICK, 24'h80_0000, '0);

        // Zero crossings needed and no tolerance: every tick ends a stage, index saturates
        settle();
        aim = dev_t'($urandom);
        apply_settings(aim, '0, '1, 32'h1000, '1, '0, '0, '0);
        queue_cmd(CMD_START, dev_t'($urandom), $urandom);
        repeat (300)
            queue_cmd(CMD_TICK, dev_t'($urandom), $urandom);

        // Random settings, each phase a few runs with stray ticks between them
        while (items_queued < ITEM_TARGET)
        begin
            settle();
            r   = $urandom_range(0, 7);
            aim = (r == 0) ? dev_t'(0) : (r == 1) ? {DEV_W{1'b1}} : dev_t'($urandom);
            case ($urandom_range(0, 9))
                0:
                begin
                    lo = '0;
                    hi = '1;
                end
                1:
                begin
                    lo = $urandom;
                    hi = $urandom;
                end
                2:
                begin
                    lo = $urandom;
                    hi = lo;
                end
                default:
                begin
                    lo = $urandom_range(32'h4000_0000, 0);
                    hi = lo + $urandom_range(32'h8000_0000, 32'h1000);
                end
            endcase
            case ($urandom_range(0, 9))
                0:       step_v = '0;
                1:       step_v = '1;
                2:       step_v = $urandom;
                default: step_v = $urandom_range(32'h0100_0000, 1);
            endcase
            r        = $urandom_range(0, 5);
            factor_v = (r == 0) ? frac_t'(0) : (r == 1) ? {FRAC_W{1'b1}} : frac_t'($urandom);
            r        = $urandom_range(0, 5);
            tol_v    = (r == 0) ? frac_t'(0) : (r == 1) ? {FRAC_W{1'b1}} : frac_t'($urandom);
            case ($urandom_range(0, 11))
                0:       passes_v = '0;
                1:       passes_v = '1;
                default: passes_v = count_t'($urandom_range(5, 1));
            endcase
            case ($urandom_range(0, 9))
                0:       max_v = '0;
                1:       max_v = '1;
                2, 3:    max_v = $urandom_range(4, 1);
                default: max_v = $urandom_range(60, 8);
            endcase
            apply_settings(aim, lo, hi, step_v, factor_v, tol_v, passes_v, max_v);
            repeat ($urandom_range(4, 2))
            begin
                queue_run(aim, lo, hi);
                if ($urandom_range(0, 3) == 0)
                    queue_cmd(CMD_TICK, dev_t'($urandom), $urandom);
            end
        end

        settle();
        if (failures == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/atrt_pkg.sv
hw/rtl/atrt_req_if.sv
hw/rtl/atrt_rsp_if.sv
hw/rtl/atrt_cfg_if.sv
hw/rtl/adaptive_temperature_rmsd_tracker_unit.sv
bench/adaptive_temperature_rmsd_tracker_unit_test.sv
